>>> rtl/clbp_pkg.sv
// Shared types, constants and LBP arithmetic for the circular LBP code unit.
package clbp_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Configuration register widths
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int ROW_W        = CFG_HEIGHT_W;
  localparam int EW_W         = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(20);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(20);
  localparam logic [EW_W-1:0]         MIN_WIDTH    = EW_W'(3);
  localparam logic [EW_W-1:0]         MAX_WIDTH_V  = EW_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]        MIN_HEIGHT   = ROW_W'(3);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Bilinear weights, Q0.8
  localparam logic [16:0] W_EDGE   = 17'd53;
  localparam logic [16:0] W_CENTER = 17'd22;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [7:0] pix_t;
  typedef logic [2:0][2:0][7:0] win_t;

  typedef struct packed {
    win_t win;
    logic last;
  } qent_t;

  // Diagonal neighbor: bilinear sum against centre * 256
  function automatic logic diag_bit(pix_t corner, pix_t a, pix_t b, pix_t c);
    logic [16:0] sum;
    sum = {2'b00, corner, 7'b0000000} + 17'(a) * W_EDGE + 17'(b) * W_EDGE
          + 17'(c) * W_CENTER;
    return (sum >= {1'b0, c, 8'h00});
  endfunction

  function automatic logic [7:0] lbp_code(win_t w);
    logic [7:0] code;
    pix_t       c;
    c       = w[1][1];
    code[0] = (w[2][1] >= c);
    code[1] = diag_bit(w[2][0], w[1][0], w[2][1], c);
    code[2] = (w[1][0] >= c);
    code[3] = diag_bit(w[0][0], w[1][0], w[0][1], c);
    code[4] = (w[0][1] >= c);
    code[5] = diag_bit(w[0][2], w[0][1], w[1][2], c);
    code[6] = (w[1][2] >= c);
    code[7] = diag_bit(w[2][2], w[2][1], w[1][2], c);
    return code;
  endfunction

endpackage

>>> rtl/clbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/clbp_front.sv
// Front end: frame counters, line store, 3x3 window and interior classification.
module clbp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  clbp_pkg::reg_idx_t               cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  clbp_pkg::pix_t                   in_pixel,
  input  logic                             q_full,
  output logic                             q_push,
  output clbp_pkg::qent_t                  q_push_data
);
  import clbp_pkg::*;

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [EW_W-1:0]         eff_w;
  logic [ROW_W-1:0]        eff_h;
  logic                    in_fire;
  logic                    col_end, row_end;

  // Stage A: pixel waiting for its line store read
  logic                    a_valid_r;
  pix_t                    a_pix_r;
  logic [COL_W-1:0]        a_col_r;
  logic                    a_emit_r;
  logic                    a_last_r;
  logic                    a_adv;

  win_t                    win_r, win_nxt;
  logic [15:0]             ram_rdata;
  pix_t                    top, mid;

  // Clamp geometry
  always_comb begin
    eff_w = EW_W'(width_r);
    if (eff_w < MIN_WIDTH) eff_w = MIN_WIDTH;
    if (eff_w > MAX_WIDTH_V) eff_w = MAX_WIDTH_V;
    eff_h = height_r;
    if (eff_h < MIN_HEIGHT) eff_h = MIN_HEIGHT;
  end

  assign a_adv    = a_valid_r && !q_full;
  assign in_ready = !a_valid_r || !q_full;
  assign in_fire  = in_valid && in_ready;

  assign col_end = (EW_W'(col_r) + EW_W'(1)) >= eff_w;
  assign row_end = (row_r + ROW_W'(1)) >= eff_h;

  // Advance raster position
  always_comb begin
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  // Configuration registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_r <= cfg_data[CFG_WIDTH_W-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= cfg_data[CFG_HEIGHT_W-1:0];
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage A control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r  <= in_pixel;
      a_col_r  <= col_r;
      a_emit_r <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      a_last_r <= row_end && col_end;
    end
  end

  // Two line rows packed per column: upper row in the high byte
  clbp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_col_r),
    .wdata ({mid, a_pix_r}),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign top = ram_rdata[15:8];
  assign mid = ram_rdata[7:0];

  // Shift the window left and load the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = top;
    win_nxt[1][2] = mid;
    win_nxt[2][2] = a_pix_r;
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      win_r <= win_nxt;
    end
  end

  // Hand interior pixels to the back end
  assign q_push           = a_adv && a_emit_r;
  assign q_push_data.win  = win_nxt;
  assign q_push_data.last = a_last_r;

endmodule

>>> rtl/clbp_queue.sv
// Short FIFO of windows between the front and back ends.
module clbp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clbp_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output clbp_pkg::qent_t pop_data
);
  import clbp_pkg::*;

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full     = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/clbp_back.sv
// Back end: LBP code evaluation and output register.
module clbp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  clbp_pkg::qent_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_lbp_code,
  output logic            out_last_of_frame
);
  import clbp_pkg::*;

  logic       out_valid_r;
  logic [7:0] code_r;
  logic       last_r;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Output valid: load on pop, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Evaluate the code as the window leaves the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      code_r <= lbp_code(q_data.win);
      last_r <= q_data.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_lbp_code      = code_r;
  assign out_last_of_frame = last_r;

endmodule

>>> rtl/circular_lbp_code_unit.sv
// Top level of the radius-1, 8-neighbor circular LBP code unit.
// A pixel passes stage A and the window queue; its code then sits in the output register.
// One pixel per cycle unless the queue backs up; one line store read and one write per pixel.
// Reset (synchronous, rst_n low): counters, queue and valids clear; width and height go to 20.
// The line store is not cleared; its first two rows of the first frame never reach a code.
module circular_lbp_code_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  clbp_pkg::reg_idx_t              cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_lbp_code,
  output logic                            out_last_of_frame
);
  import clbp_pkg::*;

  logic  q_push, q_full, q_pop, q_valid;
  qent_t q_push_data, q_pop_data;

  // Front end
  clbp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel    (in_pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Window queue
  clbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  // Back end
  clbp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_pop_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_lbp_code      (out_lbp_code),
    .out_last_of_frame (out_last_of_frame)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("window queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("window queue underflow");

  // A new result appears only after a window left the queue
  a_out_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result without a popped window");

  // A stalled result with room downstream blocked must not lose the queue head
  a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("queue popped while output stalled");

endmodule

>>> test/circular_lbp_code_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the circular LBP code unit: streamed frames checked against a local predictor.
module circular_lbp_code_unit_tb;
  import clbp_pkg::*;

  // Indexes past the two defined registers; writes there must be dropped
  localparam reg_idx_t REG_SPARE_A = 2'd2;
  localparam reg_idx_t REG_SPARE_B = 2'd3;

  localparam int RANDOM_PIXELS  = 900;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_MSG_LINES  = 40;

  typedef enum int {PIX_UNIFORM, PIX_BAND, PIX_EXTREME, PIX_FLAT} pix_mode_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } lbp_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  reg_idx_t              cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pix_t                  in_pixel  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_lbp_code;
  logic                  out_last_of_frame;

  // Predictor state: line store, 3x3 window [row][col], raster position, geometry
  pix_t                    line_mem [0:2*MAX_WIDTH-1];
  pix_t                    win [0:2][0:2];
  int unsigned             col_pos;
  int unsigned             row_pos;
  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;

  lbp_result_t pending_codes[$];
  int          err_count  = 0;
  bit          idle_on    = 1'b0;
  int          ready_hold = 0;

  circular_lbp_code_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_lbp_code      (out_lbp_code),
    .out_last_of_frame (out_last_of_frame)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_MSG_LINES) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic int unsigned frame_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned frame_height();
    int unsigned h;
    h = 32'(height_reg);
    if (h < 3) h = 3;
    return h;
  endfunction

  // Bilinear diagonal sample in Q8.8 against center scaled by 256
  function automatic bit diag_ge(input pix_t corner, input pix_t a, input pix_t b,
                                 input pix_t c);
    int unsigned sum;
    sum = 128 * 32'(corner) + 53 * 32'(a) + 53 * 32'(b) + 22 * 32'(c);
    return sum >= 256 * 32'(c);
  endfunction

  function automatic logic [7:0] window_code();
    pix_t       c;
    logic [7:0] code;
    c       = win[1][1];
    code[0] = (win[2][1] >= c);
    code[1] = diag_ge(win[2][0], win[1][0], win[2][1], c);
    code[2] = (win[1][0] >= c);
    code[3] = diag_ge(win[0][0], win[1][0], win[0][1], c);
    code[4] = (win[0][1] >= c);
    code[5] = diag_ge(win[0][2], win[0][1], win[1][2], c);
    code[6] = (win[1][2] >= c);
    code[7] = diag_ge(win[2][2], win[2][1], win[1][2], c);
    return code;
  endfunction

  // Shift one pixel through the window and line store, queue a code for interior pixels
  function automatic void advance_lbp_model(input pix_t pix);
    int unsigned w;
    int unsigned h;
    pix_t        above;
    pix_t        middle;
    lbp_result_t res;
    int          r;
    w      = frame_width();
    h      = frame_height();
    above  = line_mem[col_pos];
    middle = line_mem[MAX_WIDTH + col_pos];
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above;
    win[1][2] = middle;
    win[2][2] = pix;
    line_mem[col_pos]             = middle;
    line_mem[MAX_WIDTH + col_pos] = pix;
    if (row_pos >= 2 && col_pos >= 2) begin
      res.code = window_code();
      res.last = (row_pos == h - 1) && (col_pos == w - 1);
      pending_codes.insert(pending_codes.size(), res);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Write one register, then leave the port quiet before returning
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = val[CFG_WIDTH_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = val[CFG_HEIGHT_W-1:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Send one pixel transaction, with an occasional idle burst ahead of it
  task automatic send_pixel(input pix_t pix);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_lbp_model(pix);
  endtask

  // Hold the input and wait until every queued code has come out
  task automatic drain_codes();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pix_t draw_pixel(input pix_mode_t mode, input pix_t base);
    int v;
    case (mode)
      PIX_BAND: begin
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pix_t'(v);
      end
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_FLAT:    return base;
      default:     return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixels(input int n, input pix_mode_t mode);
    pix_t base;
    base = pix_t'($urandom_range(0, 255));
    repeat (n) send_pixel(draw_pixel(mode, base));
  endtask

  // 3x3 frame: one center value surrounded by one ring value
  task automatic send_ring_frame(input pix_t center, input pix_t ring);
    for (int k = 0; k < 9; k++) begin
      send_pixel((k == 4) ? center : ring);
    end
  endtask

  // Receiver side: random stall bursts while idling is enabled
  initial begin
    forever begin
      @(posedge clk);
      if (ready_hold == 0 && idle_on && $urandom_range(0, 6) == 0) begin
        ready_hold = $urandom_range(1, 9);
      end
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each code transaction with the oldest prediction
  always @(posedge clk) begin : check_codes
    lbp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("code %02h with nothing pending", out_lbp_code));
      end else begin
        want = pending_codes.pop_front();
        if (out_lbp_code !== want.code) begin
          report_mismatch($sformatf("lbp_code %02h, want %02h", out_lbp_code, want.code));
        end
        if (out_last_of_frame !== want.last) begin
          report_mismatch($sformatf("last_of_frame %b, want %b", out_last_of_frame,
                                    want.last));
        end
      end
    end
  end

  // Default 20x20 geometry straight out of reset
  task automatic test_reset_geometry();
    send_pixels(400, PIX_UNIFORM);
    drain_codes();
  endtask

  // Register values below 3 act as 3; equal, darker and brighter rings
  task automatic test_min_geometry();
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    send_ring_frame(8'd100, 8'd100);
    send_ring_frame(8'hFF, 8'h00);
    send_ring_frame(8'h00, 8'hFF);
    drain_codes();
  endtask

  // Writes past the register list must not restart the frame
  task automatic test_unused_index();
    write_reg(REG_IMAGE_WIDTH, 12'd5);
    write_reg(REG_IMAGE_HEIGHT, 12'd4);
    send_pixels(7, PIX_UNIFORM);
    drain_codes();
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 4095)));
    write_reg(REG_SPARE_B, 12'hFFF);
    send_pixels(13 + 20, PIX_UNIFORM);
    drain_codes();
  endtask

  // Any register write restarts at row 0, column 0, even with the same value
  task automatic test_restart_on_write();
    write_reg(REG_IMAGE_WIDTH, 12'd6);
    write_reg(REG_IMAGE_HEIGHT, 12'd5);
    send_pixels(17, PIX_BAND);
    drain_codes();
    write_reg(REG_IMAGE_HEIGHT, 12'd5);
    send_pixels(30, PIX_UNIFORM);
    drain_codes();
  endtask

  // Tallest frame: run a few rows, the next write cuts it short
  task automatic test_tall_frame();
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
    send_pixels(30, PIX_UNIFORM);
    drain_codes();
  endtask

  // Random geometry and content: mostly whole frames, some cut short
  task automatic test_random_frames();
    int        sent;
    int        n;
    int        frame_px;
    int        half;
    bit        drained_once;
    pix_mode_t mode;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    sent         = 0;
    drained_once = 1'b0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w = CFG_DATA_W'($urandom_range(0, 2));
        1:       w = 12'h800 | CFG_DATA_W'($urandom_range(3, 12));
        2:       w = CFG_DATA_W'($urandom_range(25, 64));
        default: w = CFG_DATA_W'($urandom_range(3, 24));
      endcase
      h = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                      : CFG_DATA_W'($urandom_range(3, 10));
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      case ($urandom_range(0, 9))
        0, 1:    mode = PIX_BAND;
        2:       mode = PIX_EXTREME;
        3:       mode = PIX_FLAT;
        default: mode = PIX_UNIFORM;
      endcase
      frame_px = frame_width() * frame_height();
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, frame_px - 1);
        send_pixels(n, mode);
      end else begin
        n = frame_px * $urandom_range(1, 3);
        if (!drained_once && sent > RANDOM_PIXELS / 2) begin
          // pause mid-stream until all codes are out, then carry on
          half = n / 2;
          send_pixels(half, mode);
          drain_codes();
          send_pixels(n - half, mode);
          drained_once = 1'b1;
        end else begin
          send_pixels(n, mode);
        end
      end
      sent += n;
      drain_codes();
    end
  endtask

  // Back-to-back frames with no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    drain_codes();
    write_reg(REG_IMAGE_WIDTH, 12'd16);
    write_reg(REG_IMAGE_HEIGHT, 12'd8);
    send_pixels(2 * 16 * 8, PIX_UNIFORM);
    drain_codes();
  endtask

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    test_reset_geometry();
    test_min_geometry();
    test_unused_index();
    test_restart_on_write();
    test_tall_frame();
    test_random_frames();
    test_full_rate();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/clbp_pkg.sv
rtl/clbp_ram.sv
rtl/clbp_front.sv
rtl/clbp_queue.sv
rtl/clbp_back.sv
rtl/circular_lbp_code_unit.sv
test/circular_lbp_code_unit_tb.sv
